/* rtl/owm_pkg.sv */
// owm_pkg: shared types, codes and sizes for the 1-wire bus master
// no dependencies
`default_nettype none
package owm_pkg;

	localparam int TIMER_BITS    = 10;
	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_BITS  = $clog2(BITS_PER_BYTE);
	localparam int CFG_DATA_BITS = 10;
	localparam int CFG_IDX_BITS  = 3;
	localparam int S_DATA_BITS   = 16;
	localparam int S_USER_BITS   = 2;
	localparam int M_DATA_BITS   = 16;

	typedef logic [TIMER_BITS-1:0]    timer_t;
	typedef logic [BIT_IDX_BITS-1:0]  bit_idx_t;
	typedef logic [BITS_PER_BYTE-1:0] byte_t;

	// request kinds carried on the slave tuser
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_RESET = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_RESET_LEAD = 3'd0,
		CFG_RESET_LOW  = 3'd1,
		CFG_PRES_WAIT  = 3'd2,
		CFG_RESET_TAIL = 3'd3,
		CFG_SLOT_LOW   = 3'd4,
		CFG_WRITE_HOLD = 3'd5,
		CFG_READ_HOLD  = 3'd6
	} cfg_idx_t;

	localparam timer_t RST_RESET_LEAD = timer_t'(7);
	localparam timer_t RST_RESET_LOW  = timer_t'(530);
	localparam timer_t RST_PRES_WAIT  = timer_t'(44);
	localparam timer_t RST_RESET_TAIL = timer_t'(150);
	localparam timer_t RST_SLOT_LOW   = timer_t'(1);
	localparam timer_t RST_WRITE_HOLD = timer_t'(40);
	localparam timer_t RST_READ_HOLD  = timer_t'(70);

	typedef struct packed {
		timer_t reset_lead;
		timer_t reset_low;
		timer_t pres_wait;
		timer_t reset_tail;
		timer_t slot_low;
		timer_t write_hold;
		timer_t read_hold;
	} owm_cfg_t;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_LEAD    = 10'b00_0000_0010,
		PH_RLOW    = 10'b00_0000_0100,
		PH_PWAIT   = 10'b00_0000_1000,
		PH_TAIL    = 10'b00_0001_0000,
		PH_SLOTLOW = 10'b00_0010_0000,
		PH_WHOLD   = 10'b00_0100_0000,
		PH_RSAMP   = 10'b00_1000_0000,
		PH_RHOLD   = 10'b01_0000_0000,
		PH_REC     = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		mode_t mode;
		byte_t tx_byte;
		logic  line_in;
	} owm_item_t;

	// first member lands in the top bits
	typedef struct packed {
		logic  rejected;
		byte_t rx_byte;
		logic  present;
		logic  done_res;
		logic  busy_res;
		logic  drive_level;
		logic  drive_enable;
	} owm_result_t;

endpackage
`default_nettype wire

/* rtl/onewire_bus_master_core.sv */
// onewire_bus_master_core: top level of the 1-wire bus master
// depends on owm_pkg, owm_cfg_regs, owm_engine
`default_nettype none
// 1-wire bus master paced by one-microsecond tick requests. Every slave
// request is either a tick or a start command (reset with presence detect,
// write byte, read byte) and carries the sampled bus level; every request
// yields exactly one result with the line drive and status after it. A
// request is captured in an input register, stepped through the engine
// and lands in the result register, so one request is taken per clock as
// long as results are drained; the engine update (one countdown
// decrement and one phase step) sets that rate. A start while a
// transaction runs is refused and flagged as rejected. Timing registers
// are written on the cfg channel, which is always ready; write them only
// while the block is idle.
module onewire_bus_master_core
	import owm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// slave stream
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [S_DATA_BITS-1:0]   s_tdata,  // tx_byte[7:0], line_in[8], zero pad
	input  wire logic [S_USER_BITS-1:0]   s_tuser,  // mode[1:0]
	// master stream
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [M_DATA_BITS-1:0]        m_tdata,  // drive_enable[0], drive_level[1],
	                                                // busy_res[2], done_res[3],
	                                                // present[4], rx_byte[12:5],
	                                                // rejected[13], zero pad
	// configuration writes
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic        valid_s1;
	owm_item_t   item_s1;
	logic        out_valid_q;
	owm_result_t out_q;
	owm_result_t result;
	owm_cfg_t    cfg;
	logic        advance;

	// request moves from the input register into the result register
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	// input register frees up in the same cycle it hands off
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode    <= mode_t'(s_tuser);
			item_s1.tx_byte <= s_tdata[BITS_PER_BYTE-1:0];
			item_s1.line_in <= s_tdata[BITS_PER_BYTE];
		end
	end

	owm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register, held while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_BITS'(out_q);

endmodule
`default_nettype wire

/* rtl/owm_cfg_regs.sv */
// owm_cfg_regs: timing register file of the 1-wire bus master
// depends on owm_pkg
`default_nettype none
module owm_cfg_regs
	import owm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]  wr_index,
	input  wire logic [CFG_DATA_BITS-1:0] wr_data,
	output owm_cfg_t                      cfg
);

	owm_cfg_t cfg_q;
	timer_t   wr_val;

	assign wr_val = timer_t'(wr_data);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_lead <= RST_RESET_LEAD;
			cfg_q.reset_low  <= RST_RESET_LOW;
			cfg_q.pres_wait  <= RST_PRES_WAIT;
			cfg_q.reset_tail <= RST_RESET_TAIL;
			cfg_q.slot_low   <= RST_SLOT_LOW;
			cfg_q.write_hold <= RST_WRITE_HOLD;
			cfg_q.read_hold  <= RST_READ_HOLD;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_RESET_LEAD: cfg_q.reset_lead <= wr_val;
				CFG_RESET_LOW:  cfg_q.reset_low  <= wr_val;
				CFG_PRES_WAIT:  cfg_q.pres_wait  <= wr_val;
				CFG_RESET_TAIL: cfg_q.reset_tail <= wr_val;
				CFG_SLOT_LOW:   cfg_q.slot_low   <= wr_val;
				CFG_WRITE_HOLD: cfg_q.write_hold <= wr_val;
				CFG_READ_HOLD:  cfg_q.read_hold  <= wr_val;
				default: ; // unknown index, write dropped
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/owm_engine.sv */
// owm_engine: transaction state and per-request step logic
// depends on owm_pkg
`default_nettype none
module owm_engine
	import owm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire owm_item_t item,
	input  wire owm_cfg_t  cfg,
	output owm_result_t    result
);

	phase_t   phase_q,  phase_n;
	mode_t    kind_q,   kind_n;
	timer_t   cnt_q,    cnt_n;
	bit_idx_t bit_q,    bit_n;
	byte_t    shift_q,  shift_n;
	logic     pres_q,   pres_n;
	logic     en_q,     en_n;
	logic     lvl_q,    lvl_n;
	byte_t    rx_q,     rx_n;
	logic     done, rej, expired, slot_end;
	timer_t   cnt_dec;

	assign expired = (cnt_q <= timer_t'(1));
	assign cnt_dec = expired ? '0 : cnt_q - timer_t'(1);

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		cnt_n    = cnt_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		pres_n   = pres_q;
		en_n     = en_q;
		lvl_n    = lvl_q;
		rx_n     = rx_q;
		done     = 1'b0;
		rej      = 1'b0;
		slot_end = 1'b0;

		if (item.mode != MODE_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				kind_n = item.mode;
				bit_n  = '0;
				en_n   = 1'b1;
				if (item.mode == MODE_RESET) begin
					lvl_n   = 1'b1;
					cnt_n   = cfg.reset_lead;
					phase_n = PH_LEAD;
				end else begin
					shift_n = (item.mode == MODE_WRITE) ? item.tx_byte : '0;
					lvl_n   = 1'b0;
					cnt_n   = cfg.slot_low;
					phase_n = PH_SLOTLOW;
				end
			end
		end else if (phase_q != PH_IDLE) begin
			cnt_n = cnt_dec;
			case (phase_q)
				PH_LEAD: if (expired) begin
					en_n    = 1'b1;
					lvl_n   = 1'b0;
					cnt_n   = cfg.reset_low;
					phase_n = PH_RLOW;
				end
				PH_RLOW: if (expired) begin
					en_n    = 1'b0;
					lvl_n   = 1'b1;
					cnt_n   = cfg.pres_wait;
					phase_n = PH_PWAIT;
				end
				PH_PWAIT: if (expired) begin
					pres_n  = ~item.line_in;
					cnt_n   = cfg.reset_tail;
					phase_n = PH_TAIL;
				end
				PH_TAIL: if (expired) begin
					en_n    = 1'b1;
					lvl_n   = 1'b1;
					phase_n = PH_IDLE;
					done    = 1'b1;
				end
				PH_SLOTLOW: if (expired) begin
					if (kind_q == MODE_WRITE) begin
						en_n    = 1'b1;
						lvl_n   = shift_q[bit_q];
						cnt_n   = cfg.write_hold;
						phase_n = PH_WHOLD;
					end else begin
						en_n    = 1'b0;
						lvl_n   = 1'b1;
						cnt_n   = cfg.read_hold;
						phase_n = PH_RSAMP;
					end
				end
				PH_WHOLD: slot_end = expired;
				PH_RSAMP: begin
					shift_n[bit_q] = item.line_in;
					phase_n        = PH_RHOLD;
					slot_end       = expired;
				end
				PH_RHOLD: slot_end = expired;
				PH_REC: if (expired) begin
					en_n    = 1'b1;
					lvl_n   = 1'b0;
					cnt_n   = cfg.slot_low;
					phase_n = PH_SLOTLOW;
				end
				default: phase_n = PH_IDLE;
			endcase

			// close a bit slot, finishing the byte after the last bit
			if (slot_end) begin
				en_n  = 1'b1;
				lvl_n = 1'b1;
				if (bit_q == bit_idx_t'(BITS_PER_BYTE - 1)) begin
					if (kind_q == MODE_READ) rx_n = shift_n;
					bit_n   = '0;
					phase_n = PH_IDLE;
					done    = 1'b1;
				end else begin
					bit_n   = bit_q + bit_idx_t'(1);
					cnt_n   = timer_t'(1);
					phase_n = PH_REC;
				end
			end
		end
	end

	always_comb begin
		result.rejected     = rej;
		result.rx_byte      = rx_n;
		result.present      = pres_n;
		result.done_res     = done;
		result.busy_res     = (phase_n != PH_IDLE);
		result.drive_level  = lvl_n;
		result.drive_enable = en_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= MODE_TICK;
			cnt_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			en_q    <= 1'b0;
			lvl_q   <= 1'b1;
			rx_q    <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			cnt_q   <= cnt_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			pres_q  <= pres_n;
			en_q    <= en_n;
			lvl_q   <= lvl_n;
			rx_q    <= rx_n;
		end
	end

endmodule
`default_nettype wire

/* tb/onewire_bus_master_core_tb.sv */
// onewire_bus_master_core_tb: self-checking bench for the 1-wire bus master core
// drives tick and start requests plus timing writes, predicts every result in a scoreboard
// depends on owm_pkg and onewire_bus_master_core
`timescale 1ns / 100ps
module onewire_bus_master_core_tb
	import owm_pkg::*;
();

	localparam int NUM_REGS           = 7;
	localparam int WATCHDOG_LIMIT     = 2000;
	localparam int IDLE_SETTLE_CYCLES = 4;
	localparam int END_DRAIN_CYCLES   = 8;
	localparam int RANDOM_PHASES      = 4;
	localparam int PHASE_REQUESTS     = 80;
	// index past the last register, writes to it must be dropped
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = CFG_IDX_BITS'(NUM_REGS);

	// bus level the sender puts on the requests of one transaction
	typedef enum logic [1:0] {
		LINE_LOW,
		LINE_HIGH,
		LINE_RANDOM
	} line_pattern_t;

	// scoreboard: tracks the master's timing, line drive and status, and
	// queues the result each accepted request should produce
	class bus_master_scoreboard;
		timer_t      timing [NUM_REGS];
		phase_t      phase;
		mode_t       kind;
		timer_t      countdown;
		bit_idx_t    bit_index;
		byte_t       shift_byte;
		logic        presence;
		logic        drv_en;
		logic        drv_lvl;
		byte_t       rx_hold;
		owm_result_t expected_results [$];
		int unsigned requests;
		int unsigned results;
		int unsigned mismatches;
		int unsigned rejects;
		int unsigned finished [4];

		function new();
			timing[CFG_RESET_LEAD] = RST_RESET_LEAD;
			timing[CFG_RESET_LOW]  = RST_RESET_LOW;
			timing[CFG_PRES_WAIT]  = RST_PRES_WAIT;
			timing[CFG_RESET_TAIL] = RST_RESET_TAIL;
			timing[CFG_SLOT_LOW]   = RST_SLOT_LOW;
			timing[CFG_WRITE_HOLD] = RST_WRITE_HOLD;
			timing[CFG_READ_HOLD]  = RST_READ_HOLD;
			phase      = PH_IDLE;
			kind       = MODE_TICK;
			countdown  = '0;
			bit_index  = '0;
			shift_byte = '0;
			presence   = 1'b0;
			drv_en     = 1'b0;
			drv_lvl    = 1'b1;
			rx_hold    = '0;
			requests   = 0;
			results    = 0;
			mismatches = 0;
			rejects    = 0;
			foreach (finished[i])
				finished[i] = 0;
		endfunction

		function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
			if (idx < NUM_REGS)
				timing[idx] = timer_t'(value);
		endfunction

		function bit busy();
			return phase != PH_IDLE;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// one tick off the timer, true when the phase ends here (zero acts as one)
		function bit tick_expired();
			if (countdown <= 1) begin
				countdown = '0;
				return 1'b1;
			end
			countdown = countdown - 1'b1;
			return 1'b0;
		endfunction

		function void open_slot();
			drv_en    = 1'b1;
			drv_lvl   = 1'b0;
			countdown = timing[CFG_SLOT_LOW];
			phase     = PH_SLOTLOW;
		endfunction

		// drive high at slot end, true once the last bit of the byte is done
		function bit close_slot();
			drv_en  = 1'b1;
			drv_lvl = 1'b1;
			if (bit_index == bit_idx_t'(BITS_PER_BYTE - 1)) begin
				if (kind == MODE_READ)
					rx_hold = shift_byte;
				bit_index = '0;
				phase     = PH_IDLE;
				return 1'b1;
			end
			bit_index = bit_index + 1'b1;
			countdown = timer_t'(1);
			phase     = PH_REC;
			return 1'b0;
		endfunction

		function void note_request(owm_item_t item);
			owm_result_t want;
			logic        done;
			logic        rej;
			done = 1'b0;
			rej  = 1'b0;
			requests++;
			if (item.mode != MODE_TICK) begin
				if (phase != PH_IDLE) begin
					rej = 1'b1;
				end else begin
					kind      = item.mode;
					bit_index = '0;
					if (item.mode == MODE_RESET) begin
						drv_en    = 1'b1;
						drv_lvl   = 1'b1;
						countdown = timing[CFG_RESET_LEAD];
						phase     = PH_LEAD;
					end else begin
						shift_byte = (item.mode == MODE_WRITE) ? item.tx_byte : '0;
						open_slot();
					end
				end
			end else begin
				case (phase)
					PH_LEAD: if (tick_expired()) begin
						drv_en    = 1'b1;
						drv_lvl   = 1'b0;
						countdown = timing[CFG_RESET_LOW];
						phase     = PH_RLOW;
					end
					PH_RLOW: if (tick_expired()) begin
						drv_en    = 1'b0;
						drv_lvl   = 1'b1;
						countdown = timing[CFG_PRES_WAIT];
						phase     = PH_PWAIT;
					end
					PH_PWAIT: if (tick_expired()) begin
						presence  = ~item.line_in;
						countdown = timing[CFG_RESET_TAIL];
						phase     = PH_TAIL;
					end
					PH_TAIL: if (tick_expired()) begin
						drv_en  = 1'b1;
						drv_lvl = 1'b1;
						phase   = PH_IDLE;
						done    = 1'b1;
					end
					PH_SLOTLOW: if (tick_expired()) begin
						if (kind == MODE_WRITE) begin
							drv_en    = 1'b1;
							drv_lvl   = shift_byte[bit_index];
							countdown = timing[CFG_WRITE_HOLD];
							phase     = PH_WHOLD;
						end else begin
							drv_en    = 1'b0;
							drv_lvl   = 1'b1;
							countdown = timing[CFG_READ_HOLD];
							phase     = PH_RSAMP;
						end
					end
					PH_WHOLD, PH_RHOLD: if (tick_expired())
						done = close_slot();
					PH_RSAMP: begin
						// first tick after release carries the data bit
						shift_byte[bit_index] = item.line_in;
						phase = PH_RHOLD;
						if (tick_expired())
							done = close_slot();
					end
					PH_REC: if (tick_expired())
						open_slot();
					default: ;
				endcase
			end
			if (rej)
				rejects++;
			if (done)
				finished[kind]++;
			want.drive_enable = drv_en;
			want.drive_level  = drv_lvl;
			want.busy_res     = (phase != PH_IDLE);
			want.done_res     = done;
			want.present      = presence;
			want.rx_byte      = rx_hold;
			want.rejected     = rej;
			expected_results.push_back(want);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				mismatches++;
				$error("%s: expected %0h, actual %0h", name, want, got);
			end
		endfunction

		function void check_result(logic [M_DATA_BITS-1:0] data);
			owm_result_t want;
			owm_result_t got;
			got = data[$bits(owm_result_t)-1:0];
			results++;
			if (expected_results.size() == 0) begin
				mismatches++;
				$error("result %h arrived with no request outstanding", data);
				return;
			end
			want = expected_results.pop_front();
			compare_field("drive_enable", want.drive_enable, got.drive_enable);
			compare_field("drive_level", want.drive_level, got.drive_level);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("present", want.present, got.present);
			compare_field("rx_byte", want.rx_byte, got.rx_byte);
			compare_field("rejected", want.rejected, got.rejected);
			compare_field("pad", '0, data[M_DATA_BITS-1:$bits(owm_result_t)]);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [S_DATA_BITS-1:0]   s_tdata = '0;   // tx_byte[7:0], line_in[8], zero pad
	logic [S_USER_BITS-1:0]   s_tuser = '0;   // mode[1:0]
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [M_DATA_BITS-1:0]   m_tdata;        // drive_enable[0], drive_level[1], busy_res[2],
	                                          // done_res[3], present[4], rx_byte[12:5],
	                                          // rejected[13], zero pad
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	bus_master_scoreboard sb = new();
	bit          gaps_on = 1'b1;      // cleared for stretches with no idling on either side
	int unsigned timing_sets = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;

	onewire_bus_master_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic line_for(line_pattern_t pattern);
		if (pattern == LINE_LOW)
			return 1'b0;
		if (pattern == LINE_HIGH)
			return 1'b1;
		return 1'($urandom_range(0, 1));
	endfunction

	// result side: check every accepted result, stall tready at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
		end else if (!m_tready) begin
			m_tready <= 1'b1;
		end else begin
			stall_left = pick_gap();
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	// one request on the slave stream; tvalid stays high into the next request
	// unless a gap is drawn, so it never gets two updates in one step
	task automatic send_request(mode_t mode, byte_t tx, logic line);
		int unsigned gap;
		owm_item_t   item;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= S_DATA_BITS'({line, tx});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		item.mode    = mode;
		item.tx_byte = tx;
		item.line_in = line;
		sb.note_request(item);
	endtask

	// start one transaction and tick it to the end; some starts land mid-run
	// and must be refused
	task automatic run_transaction(mode_t mode, byte_t tx, line_pattern_t pattern,
	                               int unsigned refuse_pct);
		send_request(mode, tx, line_for(pattern));
		while (sb.busy()) begin
			if ($urandom_range(0, 99) < refuse_pct)
				send_request(mode_t'($urandom_range(MODE_RESET, MODE_READ)), byte_t'($urandom),
				             line_for(pattern));
			else
				send_request(MODE_TICK, byte_t'($urandom), line_for(pattern));
		end
	endtask

	// hold requests off until every result is back and the pipeline is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_config(idx, value);
	endtask

	// every register gets a value in [lo, hi]; the spare index gets junk
	task automatic program_timing(timer_t lo, timer_t hi);
		for (int i = 0; i < NUM_REGS; i++) begin
			write_reg(CFG_IDX_BITS'(i), timer_t'($urandom_range(lo, hi)));
			if (i == CFG_PRES_WAIT)
				write_reg(CFG_IDX_SPARE, CFG_DATA_BITS'($urandom));
		end
		cfg_valid <= 1'b0;
		timing_sets++;
	endtask

	initial begin
		int unsigned phase_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-on lead, presence wait and slot low; the long phases are cut
		// short first so the run stays brief
		write_reg(CFG_RESET_LOW, timer_t'(2));
		write_reg(CFG_RESET_TAIL, timer_t'(2));
		write_reg(CFG_WRITE_HOLD, timer_t'(2));
		write_reg(CFG_READ_HOLD, timer_t'(2));
		cfg_valid <= 1'b0;
		run_transaction(MODE_RESET, 8'h00, LINE_RANDOM, 0);
		run_transaction(MODE_WRITE, byte_t'($urandom), LINE_RANDOM, 0);
		run_transaction(MODE_READ, 8'h00, LINE_RANDOM, 0);
		settle();

		// directed: shortest timing, idle ticks, refused starts, presence both ways,
		// extreme bytes written and read
		program_timing(timer_t'(1), timer_t'(1));
		send_request(MODE_TICK, 8'hFF, 1'b0);
		send_request(MODE_TICK, 8'h00, 1'b1);
		send_request(MODE_RESET, 8'h00, 1'b1);
		send_request(MODE_WRITE, 8'hFF, 1'b0);
		send_request(MODE_READ, 8'h00, 1'b1);
		send_request(MODE_RESET, 8'hFF, 1'b0);
		while (sb.busy())
			send_request(MODE_TICK, 8'h00, 1'b0);
		run_transaction(MODE_RESET, 8'hFF, LINE_HIGH, 0);
		run_transaction(MODE_WRITE, 8'hFF, LINE_RANDOM, 0);
		run_transaction(MODE_WRITE, 8'h00, LINE_RANDOM, 0);
		run_transaction(MODE_READ, 8'h00, LINE_HIGH, 0);
		run_transaction(MODE_READ, 8'hFF, LINE_LOW, 0);
		settle();

		// all registers zero: every phase should last a single tick
		program_timing(timer_t'(0), timer_t'(0));
		run_transaction(MODE_RESET, byte_t'($urandom), LINE_RANDOM, 10);
		run_transaction(MODE_WRITE, byte_t'($urandom), LINE_RANDOM, 10);
		run_transaction(MODE_READ, byte_t'($urandom), LINE_RANDOM, 10);

		// random phases: mostly complete transactions back to back, with idle
		// ticks and refused starts mixed in; one phase runs without idling
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			program_timing(timer_t'(0), (p == RANDOM_PHASES - 1) ? timer_t'(12) : timer_t'(4));
			gaps_on = (p != 1);
			phase_start = sb.requests;
			while (sb.requests < phase_start + PHASE_REQUESTS) begin
				if ($urandom_range(0, 99) < 15)
					send_request(MODE_TICK, byte_t'($urandom), 1'($urandom_range(0, 1)));
				else
					run_transaction(mode_t'($urandom_range(MODE_RESET, MODE_READ)),
					                byte_t'($urandom), LINE_RANDOM, 8);
			end
		end
		gaps_on = 1'b1;

		// drain and close out
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (END_DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d results checked, power-on timing plus %0d sets",
		         sb.requests, sb.results, timing_sets);
		$display("finished: reset %0d, write %0d, read %0d; starts refused while busy: %0d",
		         sb.finished[MODE_RESET], sb.finished[MODE_WRITE], sb.finished[MODE_READ],
		         sb.rejects);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/owm_pkg.sv
rtl/owm_cfg_regs.sv
rtl/owm_engine.sv
rtl/onewire_bus_master_core.sv
tb/onewire_bus_master_core_tb.sv
